/* src/bsa_pkg.sv */
// Shared types and constants for the bitmap slot allocator.
// Holds field widths, reset values, command and status codes, and the FSM state type.
// No dependencies.
package bsa_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int NUM_WORDS_DEF = 256;

	localparam int IDX_W    = 13;
	localparam int LIMIT_W  = 14;
	localparam int STATUS_W = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 14'd8192;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_BADINDEX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_WORD
	} state_t;

endpackage

/* src/bitmap_slot_allocator_top.sv */
// Top level of the bitmap slot allocator: control FSM, cached word, stack pointers.
// Depends on bsa_pkg, bsa_ram (bitmap and partial-word stack) and bsa_ffz.
//
// Usage
//   Command channel: drive cmd/free_index with start high; the beat is taken at a
//   rising edge where start is high and busy is low. cmd = allocate or free.
//   Result channel: done pulses for one cycle with slot_index and status. There is
//   no backpressure; the receiver must take every beat.
//   Config: cfg_we writes unit_limit from cfg_wdata. Write only while busy is low
//   and no result is pending.
// Paths (states after the accept edge; the result is registered in the last one)
//   S_EXEC: allocate from the cached word, allocate a fresh word, free into the
//     cached word, free into a never-opened word, and commands rejected there.
//   S_EXEC, S_WORD: free into another opened word (write-back plus bitmap read).
//   S_EXEC, S_POP, S_WORD: allocate that pops a partly free word (stack read,
//     then bitmap read).
// Commands run one at a time; start is taken again in the cycle that done shows.
// Reset: word 0 is open and cached and empty, the stack is empty, unit_limit is
//   8192. The RAMs need no clearing; only entries already written are ever read.
module bitmap_slot_allocator_top import bsa_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int NUM_WORDS = NUM_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [IDX_W-1:0]    free_index,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_wdata,
	output logic                done,
	output logic [IDX_W-1:0]    slot_index,
	output logic [STATUS_W-1:0] status
);

	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int POS_W  = $clog2(NUM_WORDS);
	localparam int CNT_W  = $clog2(NUM_WORDS + 1);
	localparam int SV_W   = $clog2(NUM_WORDS * WORD_BITS);
	localparam int CMP_W  = (SV_W > LIMIT_W) ? SV_W : LIMIT_W;
	// index / WORD_BITS by reciprocal; quotient is low by at most one
	localparam int RCP_SH = IDX_W + 8;
	localparam int RCP    = (1 << RCP_SH) / WORD_BITS;
	localparam int RCP_W  = RCP_SH - 2;
	localparam int Q_W    = IDX_W - 2;
	localparam int UCMP_W = (Q_W > CNT_W) ? Q_W : CNT_W;

	state_t state_q, state_d;

	logic                 accept;
	logic                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [Q_W-1:0]       q0_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [WORD_BITS-1:0] cached_q, cached_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     opened_q, opened_d;
	logic                 done_q, done_d;
	logic [IDX_W-1:0]     slot_q, slot_d;
	status_t              status_q, status_d;

	logic [IDX_W+RCP_W-1:0] q_prod;

	// divide stage
	logic [IDX_W-1:0] q_mul;
	logic [IDX_W-1:0] rem_raw;
	logic             rem_wrap;
	logic [Q_W-1:0]   unit;
	logic [BIT_W-1:0] rem;

	// memories
	logic                 bm_we, bm_re;
	logic [POS_W-1:0]     bm_waddr, bm_raddr;
	logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
	logic                 stk_we, stk_re;
	logic [POS_W-1:0]     stk_waddr, stk_raddr;
	logic [POS_W-1:0]     stk_wdata, stk_rdata;

	// find-first-zero
	logic [WORD_BITS-1:0] ffz_word;
	logic [BIT_W-1:0]     ffz_pos;
	logic                 ffz_full;

	logic                 cached_full;
	logic [WORD_BITS-1:0] set_mask, clr_mask, freed_word;
	logic [CMP_W-1:0]     lim_x, slot_cache, slot_fresh, slot_pop;
	logic [CNT_W-1:0]     cnt_m1;
	logic                 bad_idx, unit_hit, unit_open, fresh_ok;
	logic                 go_pop, go_word;

	assign accept = start & ~busy;
	assign busy   = (state_q != S_IDLE);

	assign q_prod = (IDX_W+RCP_W)'(free_index) * (IDX_W+RCP_W)'(RCP);

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			idx_q <= free_index;
			q0_q  <= q_prod[IDX_W+RCP_W-1:RCP_SH];
		end
	end

	// quotient correction: rem_raw < 2*WORD_BITS
	assign q_mul    = IDX_W'(q0_q * WORD_BITS);
	assign rem_raw  = idx_q - q_mul;
	assign rem_wrap = (rem_raw >= IDX_W'(WORD_BITS));
	assign unit     = rem_wrap ? (q0_q + Q_W'(1)) : q0_q;
	assign rem      = rem_wrap ? BIT_W'(rem_raw - IDX_W'(WORD_BITS)) : BIT_W'(rem_raw);

	// the word just read in S_WORD, else the cached word
	assign ffz_word = (state_q == S_WORD) ? bm_rdata : cached_q;

	bsa_ffz #(
		.WORD_BITS(WORD_BITS)
	) u_ffz (
		.word    (ffz_word),
		.bit_pos (ffz_pos),
		.full    (ffz_full)
	);

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	bsa_ram #(
		.WIDTH(POS_W),
		.DEPTH(NUM_WORDS)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign cached_full = (cached_q == {WORD_BITS{1'b1}});
	assign set_mask    = WORD_BITS'(1) << ffz_pos;
	assign clr_mask    = ~(WORD_BITS'(1) << rem);
	assign freed_word  = bm_rdata & clr_mask;
	assign cnt_m1      = count_q - CNT_W'(1);

	assign lim_x      = CMP_W'(limit_q);
	assign slot_cache = CMP_W'(CMP_W'(pos_q) * CMP_W'(WORD_BITS)) + CMP_W'(ffz_pos);
	assign slot_fresh = CMP_W'(CMP_W'(opened_q) * CMP_W'(WORD_BITS));
	assign slot_pop   = CMP_W'(CMP_W'(stk_rdata) * CMP_W'(WORD_BITS)) + CMP_W'(ffz_pos);

	assign bad_idx   = (LIMIT_W'(idx_q) >= limit_q);
	assign unit_hit  = (UCMP_W'(unit) == UCMP_W'(pos_q));
	assign unit_open = (UCMP_W'(unit) < UCMP_W'(opened_q));
	assign fresh_ok  = (opened_q < CNT_W'(NUM_WORDS)) && (slot_fresh < lim_x);

	assign go_pop  = (cmd_q == CMD_ALLOC) && cached_full && (count_q != '0);
	assign go_word = (cmd_q == CMD_FREE) && !bad_idx && !unit_hit && unit_open;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (go_pop) begin
					state_d = S_POP;
				end else if (go_word) begin
					state_d = S_WORD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_POP:  state_d = S_WORD;
			S_WORD: state_d = S_IDLE;
		endcase
	end

	// datapath, memory strobes and result
	always_comb begin
		cached_d  = cached_q;
		pos_d     = pos_q;
		count_d   = count_q;
		opened_d  = opened_q;
		done_d    = 1'b0;
		slot_d    = '0;
		status_d  = ST_OK;
		bm_we     = 1'b0;
		bm_waddr  = pos_q;
		bm_wdata  = cached_q;
		bm_re     = 1'b0;
		bm_raddr  = POS_W'(unit);
		stk_we    = 1'b0;
		stk_waddr = count_q[POS_W-1:0];
		stk_wdata = pos_q;
		stk_re    = 1'b0;
		stk_raddr = cnt_m1[POS_W-1:0];

		unique case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				if (cmd_q == CMD_ALLOC) begin
					priority if (!cached_full) begin
						done_d = 1'b1;
						if (slot_cache >= lim_x) begin
							status_d = ST_NOSPACE;
						end else begin
							cached_d = cached_q | set_mask;
							slot_d   = slot_cache[IDX_W-1:0];
						end
					end else if (count_q != '0) begin
						// top of stack read; bitmap read follows in S_POP
						stk_re = 1'b1;
					end else if (fresh_ok) begin
						done_d   = 1'b1;
						bm_we    = 1'b1;
						cached_d = WORD_BITS'(1);
						pos_d    = opened_q[POS_W-1:0];
						opened_d = opened_q + CNT_W'(1);
						slot_d   = slot_fresh[IDX_W-1:0];
					end else begin
						done_d   = 1'b1;
						status_d = ST_NOSPACE;
					end
				end else begin
					priority if (bad_idx) begin
						done_d   = 1'b1;
						status_d = ST_BADINDEX;
					end else if (unit_hit) begin
						done_d   = 1'b1;
						cached_d = cached_q & clr_mask;
					end else if (unit_open) begin
						// write back cached word, fetch target word (different entry)
						bm_we = 1'b1;
						bm_re = 1'b1;
					end else begin
						// word never opened: nothing to release
						done_d = 1'b1;
					end
				end
			end
			S_POP: begin
				bm_re    = 1'b1;
				bm_raddr = stk_rdata;
			end
			S_WORD: begin
				done_d = 1'b1;
				if (cmd_q == CMD_ALLOC) begin
					if (ffz_full || (slot_pop >= lim_x)) begin
						status_d = ST_NOSPACE;
					end else begin
						bm_we    = 1'b1;
						count_d  = cnt_m1;
						cached_d = bm_rdata | set_mask;
						pos_d    = stk_rdata;
						slot_d   = slot_pop[IDX_W-1:0];
					end
				end else begin
					bm_we    = 1'b1;
					bm_waddr = POS_W'(unit);
					bm_wdata = freed_word;
					if (bm_rdata == {WORD_BITS{1'b1}}) begin
						// word was full: it becomes the cached one
						if (!cached_full && (count_q < CNT_W'(NUM_WORDS))) begin
							stk_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
						cached_d = freed_word;
						pos_d    = POS_W'(unit);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			limit_q  <= LIMIT_RST;
			cached_q <= '0;
			pos_q    <= '0;
			count_q  <= '0;
			opened_q <= CNT_W'(1);
			done_q   <= 1'b0;
			slot_q   <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			cached_q <= cached_d;
			pos_q    <= pos_d;
			count_q  <= count_d;
			opened_q <= opened_d;
			done_q   <= done_d;
			slot_q   <= slot_d;
			status_q <= status_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	assign done       = done_q;
	assign slot_index = slot_q;
	assign status     = status_q;

endmodule

/* src/bsa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// rdata holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/bsa_ffz.sv */
// Find-first-zero: lowest clear bit of one bitmap word.
// No dependencies.
module bsa_ffz #(
	parameter int WORD_BITS = 32
) (
	input  logic [WORD_BITS-1:0]         word,
	output logic [$clog2(WORD_BITS)-1:0] bit_pos,
	output logic                         full
);

	localparam int BIT_W = $clog2(WORD_BITS);

	assign full = (word == {WORD_BITS{1'b1}});

	// scan from the top so the lowest clear bit wins
	always_comb begin
		bit_pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				bit_pos = BIT_W'(i);
			end
		end
	end

endmodule

/* src/bsa_checker.sv */
// Port-level checker for the bitmap slot allocator, bound to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator_top.
module bsa_checker import bsa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [IDX_W-1:0]    slot_index,
	input logic [STATUS_W-1:0] status
);

	// a taken command keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a command beat");

	// each command passes S_EXEC before its result, so result beats never touch
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats in consecutive cycles");

	// the result beat shows only once the block is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// a failed result carries slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (slot_index == '0))
		else $error("nonzero slot on a failed command");

	// no result beat in the cycle after a command beat
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result beat right after a command beat");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.slot_index (slot_index),
	.status     (status)
);
